@@ rtl/srw_pkg.sv @@
`timescale 1ns / 1ps

package srw_pkg;

    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_ADDR_BITS = 2;
    localparam int CNT_BITS      = 32;
    localparam int ACT_BITS      = 2;
    localparam int END_BITS      = 49;
    localparam int LEAP_FACTOR   = 10;
    localparam int LEAP_BITS     = 36;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_SILENCE  = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_STALL    = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_COOLDOWN = 2'd2;

    localparam logic [CFG_DATA_BITS-1:0] SILENCE_RESET  = 32'd3000;
    localparam logic [CFG_DATA_BITS-1:0] STALL_RESET    = 32'd5000;
    localparam logic [CFG_DATA_BITS-1:0] COOLDOWN_RESET = 32'd10000;

    localparam logic [ACT_BITS-1:0] ACT_NONE      = 2'd0;
    localparam logic [ACT_BITS-1:0] ACT_RECONNECT = 2'd1;
    localparam logic [ACT_BITS-1:0] ACT_RESTART   = 2'd2;

    localparam int OUT_RAW_BITS = 2 * CNT_BITS + 1 + END_BITS;
    localparam int OUT_BITS     = ((OUT_RAW_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic [CFG_DATA_BITS-1:0] silence_limit_ms;
        logic [CFG_DATA_BITS-1:0] stall_limit_ms;
        logic [CFG_DATA_BITS-1:0] quiet_ms;
        logic [LEAP_BITS-1:0]     leap_limit_ms;
    } t_cfg;

    typedef struct packed {
        logic [ACT_BITS-1:0] action;
        logic [CNT_BITS-1:0] reconnect_total;
        logic [CNT_BITS-1:0] restart_total;
        logic                cooldown_known;
        logic [END_BITS-1:0] cooldown_end_ms;
    } t_result;

endpackage

@@ rtl/srw_cfg.sv @@
`timescale 1ns / 1ps

module srw_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [srw_pkg::CFG_ADDR_BITS-1:0]   i_cfg_addr,
    input  logic [srw_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    output srw_pkg::t_cfg                       o_cfg
);
    import srw_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.silence_limit_ms <= SILENCE_RESET;
            r_cfg.stall_limit_ms   <= STALL_RESET;
            r_cfg.quiet_ms         <= COOLDOWN_RESET;
            r_cfg.leap_limit_ms    <= LEAP_BITS'(SILENCE_RESET) * LEAP_BITS'(LEAP_FACTOR);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                CFG_SILENCE: begin
                    r_cfg.silence_limit_ms <= i_cfg_data;
                    r_cfg.leap_limit_ms    <= LEAP_BITS'(i_cfg_data) * LEAP_BITS'(LEAP_FACTOR);
                end
                CFG_STALL:    r_cfg.stall_limit_ms <= i_cfg_data;
                CFG_COOLDOWN: r_cfg.quiet_ms       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/srw_core.sv @@
`timescale 1ns / 1ps

module srw_core #(
    parameter int TIME_BITS = 48
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_advance,
    input  srw_pkg::t_cfg                     i_cfg,
    input  logic [TIME_BITS-1:0]              i_now_ms,
    input  logic                              i_stream_up,
    input  logic                              i_datagram_seen,
    input  logic [TIME_BITS-1:0]              i_last_datagram_ms,
    input  logic                              i_decode_pending,
    input  logic [TIME_BITS-1:0]              i_pending_since_ms,
    input  logic [srw_pkg::CNT_BITS-1:0]      i_decoder_chatter,
    output srw_pkg::t_result                  o_result
);
    import srw_pkg::*;

    localparam int CMP_W = (TIME_BITS > LEAP_BITS) ? TIME_BITS : LEAP_BITS;
    localparam int SUM_W = (TIME_BITS + 1 > END_BITS) ? TIME_BITS + 1 : END_BITS;

    logic                 r_prev_valid;
    logic [TIME_BITS-1:0] r_prev_ms;
    logic                 r_acted_valid;
    logic [TIME_BITS-1:0] r_acted_ms;
    logic [CNT_BITS-1:0]  r_prev_chatter;
    logic                 r_chatter_seeded;
    logic [CNT_BITS-1:0]  r_reconnect_cnt;
    logic [CNT_BITS-1:0]  r_restart_cnt;

    logic                 n_acted_valid;
    logic [TIME_BITS-1:0] n_acted_ms;
    logic [CNT_BITS-1:0]  n_reconnect_cnt;
    logic [CNT_BITS-1:0]  n_restart_cnt;

    function automatic logic [TIME_BITS:0] f_diff(
        input logic [TIME_BITS-1:0] a,
        input logic [TIME_BITS-1:0] b
    );
        return {1'b0, a} - {1'b0, b};
    endfunction

    function automatic logic f_ge(
        input logic [TIME_BITS:0] d,
        input logic [CMP_W-1:0]   limit
    );
        return !d[TIME_BITS] && (CMP_W'(d[TIME_BITS-1:0]) >= limit);
    endfunction

    logic [TIME_BITS:0] delta;
    logic [TIME_BITS:0] dg_age;
    logic [TIME_BITS:0] pend_age;
    logic [TIME_BITS:0] act_age;
    logic               backward;
    logic               leap;
    logic               trusted;
    logic               cooling;
    logic               silent;
    logic               spoke;
    logic               stalled;
    logic               do_reconnect;
    logic               do_restart;
    logic               take_now;
    logic               cd_on;
    logic [SUM_W-1:0]   end_now;
    logic [SUM_W-1:0]   end_old;

    always_comb begin
        delta    = f_diff(i_now_ms, r_prev_ms);
        dg_age   = f_diff(i_now_ms, i_last_datagram_ms);
        pend_age = f_diff(i_now_ms, i_pending_since_ms);
        act_age  = f_diff(i_now_ms, r_acted_ms);
        cd_on    = (i_cfg.quiet_ms != '0);

        backward = r_prev_valid && delta[TIME_BITS];
        leap     = r_prev_valid && (i_cfg.leap_limit_ms != '0)
                   && f_ge(delta, CMP_W'(i_cfg.leap_limit_ms));
        trusted  = !(backward || leap);

        cooling  = cd_on && r_acted_valid
                   && !f_ge(act_age, CMP_W'(i_cfg.quiet_ms));
        silent   = i_stream_up && i_datagram_seen
                   && f_ge(dg_age, CMP_W'(i_cfg.silence_limit_ms));
        spoke    = r_chatter_seeded && (i_decoder_chatter != r_prev_chatter);
        stalled  = i_decode_pending && !spoke
                   && f_ge(pend_age, CMP_W'(i_cfg.stall_limit_ms));

        do_reconnect = trusted && silent && !cooling;
        do_restart   = trusted && !silent && stalled && !cooling;
        take_now     = do_reconnect || do_restart || (leap && r_acted_valid);

        n_acted_valid = r_acted_valid || do_reconnect || do_restart;
        n_acted_ms    = take_now ? i_now_ms : r_acted_ms;

        n_reconnect_cnt = r_reconnect_cnt;
        if (do_reconnect && (r_reconnect_cnt != '1)) begin
            n_reconnect_cnt = r_reconnect_cnt + CNT_BITS'(1);
        end
        n_restart_cnt = r_restart_cnt;
        if (do_restart && (r_restart_cnt != '1)) begin
            n_restart_cnt = r_restart_cnt + CNT_BITS'(1);
        end

        end_now = SUM_W'(i_now_ms) + SUM_W'(i_cfg.quiet_ms);
        end_old = SUM_W'(r_acted_ms) + SUM_W'(i_cfg.quiet_ms);

        if (do_reconnect) begin
            o_result.action = ACT_RECONNECT;
        end else if (do_restart) begin
            o_result.action = ACT_RESTART;
        end else begin
            o_result.action = ACT_NONE;
        end
        o_result.reconnect_total = n_reconnect_cnt;
        o_result.restart_total   = n_restart_cnt;
        o_result.cooldown_known  = n_acted_valid && cd_on;
        if (n_acted_valid && cd_on) begin
            o_result.cooldown_end_ms = take_now ? end_now[END_BITS-1:0]
                                                : end_old[END_BITS-1:0];
        end else begin
            o_result.cooldown_end_ms = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_valid     <= 1'b0;
            r_prev_ms        <= '0;
            r_acted_valid    <= 1'b0;
            r_acted_ms       <= '0;
            r_prev_chatter   <= '0;
            r_chatter_seeded <= 1'b0;
            r_reconnect_cnt  <= '0;
            r_restart_cnt    <= '0;
        end else if (i_advance) begin
            r_prev_valid     <= 1'b1;
            r_prev_ms        <= i_now_ms;
            r_acted_valid    <= n_acted_valid;
            r_acted_ms       <= n_acted_ms;
            r_prev_chatter   <= i_decoder_chatter;
            r_chatter_seeded <= 1'b1;
            r_reconnect_cnt  <= n_reconnect_cnt;
            r_restart_cnt    <= n_restart_cnt;
        end
    end

endmodule

@@ rtl/stream_recovery_watchdog.sv @@
`timescale 1ns / 1ps
// Stream recovery watchdog.
// The slave stream carries one tick transaction per timer tick; the master
// stream returns exactly one decision transaction per tick, in order.
// action in m_axis_tuser is none, reconnect stream or restart decoder; tdata
// carries the saturating action totals and the end of the cooldown window.
// The config channel writes silence, stall and cooldown limits (index 0..2);
// it is always ready; the user must write it only while no tick is in flight (unenforced).
// A tick accepted into the tick register is offered on the master side from
// the decision register (two register stages: tick register, decision register).
// Throughput: one tick per cycle while the master side does not stall; the
// decision for the tick in the tick register comes combinationally from the
// subtract-and-compare logic on the watchdog state, updated in that same cycle.
// Reset clears the history, action totals and cooldown, and restores the
// limits to 3000, 5000 and 10000 ms.
// When the master side stalls, the decision register holds; one more tick is
// taken into the tick register, after which s_axis_tready drops.
module stream_recovery_watchdog #(
    parameter int TIME_BITS = 48
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // now_ms, stream_up, last_datagram_ms, pending_since_ms, decoder_chatter
    input  logic [((3*TIME_BITS+33+7)/8)*8-1:0]   s_axis_tdata,
    // datagram_seen, decode_pending
    input  logic [1:0]                            s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // reconnect_total, restart_total, cooldown_known, cooldown_end_ms
    output logic [srw_pkg::OUT_BITS-1:0]          m_axis_tdata,
    // action
    output logic [srw_pkg::ACT_BITS-1:0]          m_axis_tuser,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [srw_pkg::CFG_ADDR_BITS-1:0]     i_cfg_addr,
    input  logic [srw_pkg::CFG_DATA_BITS-1:0]     i_cfg_data
);
    import srw_pkg::*;

    localparam int OFS_UP     = TIME_BITS;
    localparam int OFS_LAST   = TIME_BITS + 1;
    localparam int OFS_SINCE  = 2 * TIME_BITS + 1;
    localparam int OFS_CHAT   = 3 * TIME_BITS + 1;

    t_cfg    cfg;
    t_result result;

    logic                 r_in_valid;
    logic [TIME_BITS-1:0] r_now_ms;
    logic                 r_stream_up;
    logic                 r_datagram_seen;
    logic [TIME_BITS-1:0] r_last_datagram_ms;
    logic                 r_decode_pending;
    logic [TIME_BITS-1:0] r_pending_since_ms;
    logic [CNT_BITS-1:0]  r_decoder_chatter;

    logic    r_out_valid;
    t_result r_out;

    logic s_accept;
    logic advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    srw_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    srw_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_advance          (advance),
        .i_cfg              (cfg),
        .i_now_ms           (r_now_ms),
        .i_stream_up        (r_stream_up),
        .i_datagram_seen    (r_datagram_seen),
        .i_last_datagram_ms (r_last_datagram_ms),
        .i_decode_pending   (r_decode_pending),
        .i_pending_since_ms (r_pending_since_ms),
        .i_decoder_chatter  (r_decoder_chatter),
        .o_result           (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_now_ms           <= s_axis_tdata[TIME_BITS-1:0];
            r_stream_up        <= s_axis_tdata[OFS_UP];
            r_last_datagram_ms <= s_axis_tdata[OFS_LAST +: TIME_BITS];
            r_pending_since_ms <= s_axis_tdata[OFS_SINCE +: TIME_BITS];
            r_decoder_chatter  <= s_axis_tdata[OFS_CHAT +: CNT_BITS];
            r_datagram_seen    <= s_axis_tuser[0];
            r_decode_pending   <= s_axis_tuser[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.action;
    assign m_axis_tdata  = OUT_BITS'({r_out.cooldown_end_ms, r_out.cooldown_known,
                                      r_out.restart_total, r_out.reconnect_total});

endmodule
